/* sv/cld_pkg.sv */
`default_nettype none

package cld_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int RING_DEPTH_DEF = 64;

  // Input word.
  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_ECHO  = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_EMPTY = 3'd2;
  localparam logic [2:0] KIND_INTR  = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  // Register indexes of the write port.
  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_ECHO   = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_CANON  = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SIGNAL = 2'd2;

  // Escape tracking.
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_INTR   = 8'd3;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_ERASE2 = 8'd145;
  localparam logic [7:0] CSI_LO    = 8'h40;
  localparam logic [7:0] CSI_HI    = 8'h7E;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] key_byte;
    logic [5:0] request_count;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [6:0] dropped_count;
    logic       last;
  } out_word_t;

endpackage

`default_nettype wire

/* sv/cld_ram.sv */
`default_nettype none

module cld_ram #(
  parameter int DEPTH = cld_pkg::LINE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/canonical_line_discipline.sv */
`default_nettype none

// Terminal line discipline. A word is taken when start is high and busy is low;
// each result word is shown on result for exactly one cycle with result_valid
// high, and the receiver cannot stall it, so it must take every word as shown.
// The last flag marks the final result of an input word; a word may cause no
// result at all. Key, interrupt, empty-read and flush results appear in the
// cycle after the accepting edge. A key byte keeps busy low, but an erase that is
// echoed as backspace, space, backspace holds busy high through the ERASE state. A
// read passes through the READ and DRAIN states: the line and ring memories each
// have one synchronous read port and deliver one byte per cycle, and each byte
// passes through the read register of its memory and then the result register.
// Interrupts, empty reads and flushes keep busy low.
module canonical_line_discipline #(
  parameter int LINE_DEPTH = cld_pkg::LINE_DEPTH_DEF,
  parameter int RING_DEPTH = cld_pkg::RING_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire cld_pkg::in_word_t            item,
  output cld_pkg::out_word_t                result,
  output logic                              result_valid,
  input  wire logic                         write_enable,
  input  wire logic [cld_pkg::REG_INDEX_W-1:0] write_index,
  input  wire logic                         write_data
);

  import cld_pkg::*;

  localparam int LW = $clog2(LINE_DEPTH);
  localparam int RW = $clog2(RING_DEPTH);
  localparam int CW = ((LW > RW) ? LW : RW) + 7;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ERASE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;

  logic          echo_en, canon_en, sig_en;
  logic [1:0]    esc;
  logic [LW-1:0] line_len;
  logic          line_done;
  logic [RW-1:0] wi, ri;
  logic [LW-1:0] ptr;
  logic [5:0]    remaining;
  logic          erase_step;
  logic          rd_pend, rd_last;

  logic          accept;
  logic [7:0]    key;
  logic          is_intr, consumed, is_erase, is_eol, line_room, line_nonempty;
  logic [1:0]    esc_next;
  logic [RW-1:0] wi_wrap, ri_wrap;
  logic          ring_full;
  logic [RW:0]   fill;
  logic [5:0]    req, read_cnt;
  logic [CW-1:0] req_ext, len_ext, fill_ext;

  logic          line_we, ring_we, rd_en;
  logic [7:0]    line_wdata, line_rdata, ring_rdata;

  function automatic out_word_t make_word(logic [2:0] kind, logic [7:0] data,
                                          logic [6:0] dropped, logic last);
    out_word_t w;
    w.kind          = kind;
    w.data_byte     = data;
    w.dropped_count = dropped;
    w.last          = last;
    return w;
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign key    = item.key_byte;
  assign req    = item.request_count;

  assign wi_wrap   = (wi == RW'(RING_DEPTH - 1)) ? '0 : wi + 1'b1;
  assign ri_wrap   = (ri == RW'(RING_DEPTH - 1)) ? '0 : ri + 1'b1;
  assign ring_full = (wi_wrap == ri);
  assign fill      = (wi >= ri) ? ((RW+1)'(wi) - (RW+1)'(ri))
                                : ((RW+1)'(wi) + (RW+1)'(RING_DEPTH) - (RW+1)'(ri));

  assign line_room     = (line_len < LW'(LINE_DEPTH - 1));
  assign line_nonempty = (line_len != '0);
  assign is_intr       = sig_en && (key == CH_INTR);
  assign is_erase      = (key == CH_BS) || (key == CH_DEL) || (key == CH_ERASE2);
  assign is_eol        = (key == CH_CR) || (key == CH_LF);

  // Escape sequence tracking; a stored code of three behaves as no escape.
  always_comb begin
    consumed = 1'b0;
    esc_next = esc;
    case (esc)
      ESC_CSI: begin
        consumed = 1'b1;
        if (key == CH_ESC) begin
          esc_next = ESC_SEEN;
        end else if (key >= CSI_LO && key <= CSI_HI) begin
          esc_next = ESC_NONE;
        end
      end
      ESC_SEEN: begin
        if (key == CH_LBRACK) begin
          esc_next = ESC_CSI;
          consumed = 1'b1;
        end else begin
          esc_next = ESC_NONE;
        end
      end
      default: begin
        esc_next = ESC_NONE;
        if (key == CH_ESC) begin
          esc_next = ESC_SEEN;
          consumed = 1'b1;
        end
      end
    endcase
  end

  // Number of bytes a read returns; zero means an empty report.
  assign req_ext  = CW'(req);
  assign len_ext  = CW'(line_len);
  assign fill_ext = CW'(fill);

  always_comb begin
    read_cnt = '0;
    if (req != '0) begin
      if (canon_en) begin
        if (line_done) begin
          read_cnt = (req_ext < len_ext) ? req : 6'(line_len);
        end
      end else begin
        read_cnt = (req_ext < fill_ext) ? req : 6'(fill);
      end
    end
  end

  // Memory writes happen only at an accepting edge and reads only while busy,
  // so a read never meets a write to the same entry.
  assign line_we    = accept && (item.mode == MODE_KEY) && !is_intr && canon_en &&
                      !consumed && !is_erase && line_room;
  assign line_wdata = is_eol ? CH_LF : key;
  assign ring_we    = accept && (item.mode == MODE_KEY) && !is_intr && !canon_en &&
                      !ring_full;
  assign rd_en      = (state == ST_READ);

  cld_ram #(.DEPTH(LINE_DEPTH), .AW(LW)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_len),
    .wdata (line_wdata),
    .re    (rd_en && canon_en),
    .raddr (ptr),
    .rdata (line_rdata)
  );

  cld_ram #(.DEPTH(RING_DEPTH), .AW(RW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wi),
    .wdata (key),
    .re    (rd_en && !canon_en),
    .raddr (ri),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      echo_en      <= 1'b1;
      canon_en     <= 1'b1;
      sig_en       <= 1'b1;
      esc          <= ESC_NONE;
      line_len     <= '0;
      line_done    <= 1'b0;
      wi           <= '0;
      ri           <= '0;
      ptr          <= '0;
      remaining    <= '0;
      erase_step   <= 1'b0;
      rd_pend      <= 1'b0;
      rd_last      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_pend      <= 1'b0;

      if (write_enable) begin
        case (write_index)
          REG_ECHO:   echo_en  <= write_data;
          REG_CANON:  canon_en <= write_data;
          REG_SIGNAL: sig_en   <= write_data;
          default: ;
        endcase
      end

      // Read data comes out of the memory in the cycle after its address.
      if (rd_pend) begin
        result_valid <= 1'b1;
        result <= make_word(KIND_DATA, canon_en ? line_rdata : ring_rdata, '0, rd_last);
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            case (item.mode)
              MODE_KEY: begin
                if (is_intr) begin
                  result_valid <= 1'b1;
                  result       <= make_word(KIND_INTR, '0, '0, 1'b1);
                end else if (!canon_en) begin
                  if (!ring_full) begin
                    wi <= wi_wrap;
                  end
                  if (echo_en) begin
                    result_valid <= 1'b1;
                    result       <= make_word(KIND_ECHO, key, '0, 1'b1);
                  end
                end else begin
                  esc <= esc_next;
                  if (!consumed) begin
                    if (is_erase) begin
                      if (line_nonempty) begin
                        line_len <= line_len - 1'b1;
                        if (echo_en) begin
                          result_valid <= 1'b1;
                          result       <= make_word(KIND_ECHO, CH_BS, '0, 1'b0);
                          erase_step   <= 1'b0;
                          state        <= ST_ERASE;
                        end
                      end
                    end else if (is_eol) begin
                      if (line_room) begin
                        line_len <= line_len + 1'b1;
                      end
                      line_done <= 1'b1;
                      if (echo_en) begin
                        result_valid <= 1'b1;
                        result       <= make_word(KIND_ECHO, CH_LF, '0, 1'b1);
                      end
                    end else if (line_room) begin
                      line_len <= line_len + 1'b1;
                      if (echo_en) begin
                        result_valid <= 1'b1;
                        result       <= make_word(KIND_ECHO, key, '0, 1'b1);
                      end
                    end
                  end
                end
              end
              MODE_READ: begin
                // A ready line is cleared by any read in canonical mode that asks for bytes.
                if (canon_en && line_done && (req != '0)) begin
                  line_len  <= '0;
                  line_done <= 1'b0;
                end
                if (read_cnt == '0) begin
                  result_valid <= 1'b1;
                  result       <= make_word(KIND_EMPTY, '0, '0, 1'b1);
                end else begin
                  remaining <= read_cnt;
                  ptr       <= '0;
                  state     <= ST_READ;
                end
              end
              MODE_FLUSH: begin
                result_valid <= 1'b1;
                result       <= make_word(KIND_FLUSH, '0, 7'(fill_ext + len_ext), 1'b1);
                wi           <= ri;
                line_len     <= '0;
                line_done    <= 1'b0;
                esc          <= ESC_NONE;
              end
              default: ;
            endcase
          end
        end
        ST_ERASE: begin
          result_valid <= 1'b1;
          if (!erase_step) begin
            result     <= make_word(KIND_ECHO, CH_SP, '0, 1'b0);
            erase_step <= 1'b1;
          end else begin
            result <= make_word(KIND_ECHO, CH_BS, '0, 1'b1);
            state  <= ST_IDLE;
          end
        end
        ST_READ: begin
          rd_pend   <= 1'b1;
          rd_last   <= (remaining == 6'd1);
          remaining <= remaining - 1'b1;
          if (canon_en) begin
            ptr <= ptr + 1'b1;
          end else begin
            ri <= ri_wrap;
          end
          if (remaining == 6'd1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
